### sv/http_date_field_parser_macros.svh
// Assertion macros for the HTTP date field parser.
`ifndef HTTP_DATE_FIELD_PARSER_MACROS_SVH
`define HTTP_DATE_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HDFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hdfp check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define HDFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hdfp check failed");

`endif

### sv/hdfp_pkg.sv
// Types, constants and per-byte parse functions for the HTTP date field parser.
package hdfp_pkg;

  localparam int unsigned MagW = 20;
  localparam logic [MagW-1:0] ACC_MAX = 20'd999999;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] TOK_DAY   = 3'd1;
  localparam logic [2:0] TOK_MONTH = 3'd2;
  localparam logic [2:0] TOK_YEAR  = 3'd3;
  localparam logic [2:0] TOK_TIME  = 3'd4;
  localparam logic [2:0] TOK_ZONE  = 3'd5;

  localparam logic [23:0] MONTH_NAMES [12] = '{
    24'h6a616e, 24'h666562, 24'h6d6172, 24'h617072, 24'h6d6179, 24'h6a756e,
    24'h6a756c, 24'h617567, 24'h736570, 24'h6f6374, 24'h6e6f76, 24'h646563
  };

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } acc_t;

  typedef struct packed {
    phase_e phase;
    acc_t   acc;
  } acc_step_t;

  typedef struct packed {
    logic        string_ended;
    logic [2:0]  token_number;
    phase_e      phase;
    acc_t        day;
    logic [23:0] month_chars;
    logic [1:0]  month_cnt;
    acc_t        year;
    logic [2:0]  year_len;
    logic [1:0]  time_cnt;
    logic [7:0]  time_c0;
    logic [7:0]  time_c1;
    logic [1:0]  colon_cnt;
    acc_t        minute;
    acc_t        second;
  } state_t;

  // Lowest bit first: date_ok, day, month, year, hour, minute, second.
  typedef struct packed {
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [20:0] years_since_1900;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic        date_ok;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic acc_step_t acc_feed(phase_e ph, acc_t a, logic [7:0] c);
    acc_step_t       r;
    logic [23:0]     prod;
    logic [MagW-1:0] sat;
    r.phase = ph;
    r.acc   = a;
    prod    = 24'(a.mag) * 24'd10 + 24'(c[3:0]);
    sat     = (prod > 24'(ACC_MAX)) ? ACC_MAX : prod[MagW-1:0];
    case (ph)
      PH_SKIP: begin
        if (c inside {[8'd9:8'd13]}) begin
          r.phase = PH_SKIP;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          r.acc.neg = (c == CH_MINUS);
          r.phase   = PH_DIGITS;
        end else if (is_digit(c)) begin
          r.acc.mag = sat;
          r.phase   = PH_DIGITS;
        end else begin
          r.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          r.acc.mag = sat;
        end else begin
          r.phase = PH_DONE;
        end
      end
      default: begin
        r.phase = ph;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c inside {[8'h41:8'h5a]}) ? c + 8'd32 : c;
  endfunction

  function automatic state_t feed_byte(state_t s, logic [7:0] c);
    state_t    r;
    acc_step_t a;
    r = s;
    a = '0;
    if (!s.string_ended) begin
      if (c == CH_NUL) begin
        r.string_ended = 1'b1;
      end else if (c == CH_SPACE) begin
        if (s.token_number < TOK_ZONE) begin
          r.token_number = s.token_number + 3'd1;
          r.phase        = PH_SKIP;
        end
      end else begin
        case (s.token_number)
          TOK_DAY: begin
            a       = acc_feed(s.phase, s.day, c);
            r.phase = a.phase;
            r.day   = a.acc;
          end
          TOK_MONTH: begin
            if (s.month_cnt < 2'd3) begin
              r.month_chars = {s.month_chars[15:0], to_lower(c)};
              r.month_cnt   = s.month_cnt + 2'd1;
            end
          end
          TOK_YEAR: begin
            a       = acc_feed(s.phase, s.year, c);
            r.phase = a.phase;
            r.year  = a.acc;
            if (s.year_len < 3'd5) begin
              r.year_len = s.year_len + 3'd1;
            end
          end
          TOK_TIME: begin
            if (s.time_cnt == 2'd0) begin
              r.time_c0  = c;
              r.time_cnt = 2'd1;
            end else if (s.time_cnt == 2'd1) begin
              r.time_c1  = c;
              r.time_cnt = 2'd2;
            end
            if (s.colon_cnt == 2'd0) begin
              if (c == CH_COLON) begin
                r.colon_cnt = 2'd1;
                r.phase     = PH_SKIP;
              end
            end else if (s.colon_cnt == 2'd1) begin
              if (c == CH_COLON) begin
                r.colon_cnt = 2'd2;
                r.phase     = PH_SKIP;
              end else begin
                a        = acc_feed(s.phase, s.minute, c);
                r.phase  = a.phase;
                r.minute = a.acc;
              end
            end else begin
              a        = acc_feed(s.phase, s.second, c);
              r.phase  = a.phase;
              r.second = a.acc;
            end
          end
          default: begin
            r.token_number = s.token_number;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic result_t build_result(state_t s);
    result_t            r;
    logic               found;
    logic [3:0]         mon;
    logic               ok;
    logic signed [21:0] yr;
    logic [10:0]        hsum;
    logic               hour_ok;
    logic               min_ok;
    logic               sec_ok;
    logic               day_ok;
    found = 1'b0;
    mon   = 4'd0;
    for (int i = 11; i >= 0; i--) begin
      if (s.month_chars == MONTH_NAMES[i]) begin
        found = 1'b1;
        mon   = 4'(i);
      end
    end
    yr = s.year.neg ? -$signed({2'b00, s.year.mag}) : $signed({2'b00, s.year.mag});
    if (s.year_len == 3'd4) begin
      yr = yr - 22'sd1900;
    end else if (yr < 22'sd70) begin
      yr = yr + 22'sd100;
    end else if (yr > 22'sd19000) begin
      yr = yr - 22'sd19000;
    end
    hsum    = (is_digit(s.time_c0) ? 11'(s.time_c0[3:0]) * 11'd10 : 11'd0)
              + 11'(s.time_c1);
    hour_ok = (s.time_cnt == 2'd2) && (hsum >= 11'd48) && (hsum <= 11'd71);
    day_ok  = !s.day.neg && (s.day.mag >= 20'd1) && (s.day.mag <= 20'd31);
    min_ok  = (s.minute.mag <= 20'd59) && (!s.minute.neg || s.minute.mag == '0);
    sec_ok  = (s.colon_cnt < 2'd2)
              || ((s.second.mag <= 20'd59) && (!s.second.neg || s.second.mag == '0));
    ok = (s.token_number >= TOK_TIME) && (s.colon_cnt >= 2'd1) && (s.month_cnt == 2'd3)
         && found && day_ok && hour_ok && min_ok && sec_ok;
    r = '0;
    if (ok) begin
      r.date_ok          = 1'b1;
      r.day_of_month     = s.day.mag[4:0];
      r.month_index      = mon;
      r.years_since_1900 = yr[20:0];
      r.hour_of_day      = 5'(hsum - 11'd48);
      r.minute_of_hour   = s.minute.mag[5:0];
      r.second_of_minute = (s.colon_cnt >= 2'd2) ? s.second.mag[5:0] : 6'd0;
    end
    return r;
  endfunction

endpackage

### sv/http_date_field_parser.sv
// Top level of the HTTP date field parser: byte stream in, parsed date fields out.

// Takes one byte of a date string per cycle on the slave stream while s_axis_tready is
// high, with tlast on the final byte. The parse state is updated as each byte is
// accepted (one multiply-by-ten-and-saturate per numeric field sets the per-byte path).
// On the last byte the final state is captured in the snapshot register, and the parsed
// fields are then registered in the output register before they appear on the master
// stream. Only the last byte of a string yields a result; the state returns to its reset
// value right after it, so the next string starts from a clean state. Output and capture
// registers let input keep flowing while one result waits for m_axis_tready.
`include "http_date_field_parser_macros.svh"

module http_date_field_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [0] date_ok, [5:1] day_of_month,
                                      // [9:6] month_index, [30:10] years_since_1900,
                                      // [35:31] hour_of_day, [41:36] minute_of_hour,
                                      // [47:42] second_of_minute
);

  hdfp_pkg::state_t  st_q, st_d, st_next;
  hdfp_pkg::state_t  snap_q, snap_d;
  logic              snap_valid_q, snap_valid_d;
  hdfp_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;
  logic              snap_ready;

  assign snap_ready    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !snap_valid_q || snap_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign st_next       = hdfp_pkg::feed_byte(st_q, s_axis_tdata);

  always_comb begin
    st_d = st_q;
    if (in_acc) begin
      st_d = s_axis_tlast ? '0 : st_next;
    end
  end

  always_comb begin
    snap_d       = snap_q;
    snap_valid_d = snap_valid_q;
    if (in_acc && s_axis_tlast) begin
      snap_d       = st_next;
      snap_valid_d = 1'b1;
    end else if (snap_ready) begin
      snap_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (snap_valid_q && snap_ready) begin
      out_d       = hdfp_pkg::build_result(snap_q);
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `HDFP_ASSERT_NOW(a_invalid_is_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata == 48'd0)
  `HDFP_ASSERT_NOW(a_fields_in_range, m_axis_tvalid && m_axis_tdata[0], (m_axis_tdata[5:1] != 5'd0) && (m_axis_tdata[9:6] <= 4'd11) && (m_axis_tdata[35:31] <= 5'd23) && (m_axis_tdata[41:36] <= 6'd59) && (m_axis_tdata[47:42] <= 6'd59))
  `HDFP_ASSERT_NEXT(a_last_captured, in_acc && s_axis_tlast, snap_valid_q)
  `HDFP_ASSERT_NEXT(a_last_clears_state, in_acc && s_axis_tlast, (st_q.token_number == 3'd0) && !st_q.string_ended && (st_q.colon_cnt == 2'd0))

endmodule
